/* rtl/pgc_pkg.sv */
// Shared types, codes and helpers for the pointer gesture classifier.
package pgc_pkg;

    localparam int unsigned MODE_W = 3;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned DD_W   = 16;
    localparam int unsigned GES_W  = 4;
    localparam int unsigned TMR_W  = 12;
    localparam int unsigned LIM_W  = 8;
    localparam int unsigned NOW_W  = 16;
    localparam int unsigned CNT_W  = 3;
    localparam int unsigned CIDX_W = 3;
    localparam int unsigned CDAT_W = 12;
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_PRESS   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MOVE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DRAG    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd5;

    localparam logic [GES_W-1:0] GES_NONE   = 4'd0;
    localparam logic [GES_W-1:0] GES_CLICK1 = 4'd1;
    localparam logic [GES_W-1:0] GES_HOLD1  = 4'd4;
    localparam logic [GES_W-1:0] GES_DRAG1  = 4'd7;
    localparam logic [GES_W-1:0] GES_PAUSE  = 4'd10;

    localparam logic [CIDX_W-1:0] REG_RELEASE_TO = 3'd0;
    localparam logic [CIDX_W-1:0] REG_GESTURE_TO = 3'd1;
    localparam logic [CIDX_W-1:0] REG_PAUSE_IVL  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DEV_LIMIT  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_DRAG_THR   = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = 3'd4;

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_EXEC, OP_RD, OP_CHK, OP_PLACE, OP_P0, OP_PCHK, OP_OUT
    } t_op;

    typedef struct packed {
        logic walk;   // move item needs a track walk
        logic pause;  // timer expiry needs a pause check
        logic more;   // read pointer still below track length
    } t_status;

    // gesture code for hold or drag, by click count
    function automatic logic [GES_W-1:0] count_code(input logic [GES_W-1:0] base,
                                                    input logic [CNT_W-1:0] cc);
        logic [GES_W-1:0] c;
        c = base + 4'd2;
        if (cc == 3'd1) c = base;
        else if (cc == 3'd2) c = base + 4'd1;
        return c;
    endfunction

endpackage

/* rtl/pgc_datapath.sv */
// Datapath: gesture state, point track, squared-distance unit and result registers.
module pgc_datapath #(
    parameter int unsigned TRACK_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pgc_pkg::t_op                  i_op,
    output pgc_pkg::t_status              o_status,
    input  logic [pgc_pkg::IN_TDATA_W-1:0] i_in_data,
    input  logic                          i_cfg_we,
    input  logic [pgc_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [pgc_pkg::CDAT_W-1:0]    i_cfg_data,
    output logic [pgc_pkg::OUT_TDATA_W-1:0] o_out_data
);
    import pgc_pkg::*;

    localparam int unsigned LW = $clog2(TRACK_DEPTH + 1);
    localparam int unsigned IW = $clog2(TRACK_DEPTH);
    localparam logic [LW-1:0] DEPTH_L = LW'(TRACK_DEPTH);

    // configuration
    logic [TMR_W-1:0] r_rel_to, r_ges_to, r_pause_ivl;
    logic [LIM_W-1:0] r_dev_lim, r_drag_thr;

    // latched item
    logic [MODE_W-1:0]       r_mode;
    logic signed [POS_W-1:0] r_px, r_py;
    logic [DD_W-1:0]         r_dd;

    // gesture state
    logic [CNT_W-1:0] r_cc;
    logic r_await_rel, r_await_end, r_await_pause, r_hold, r_drag, r_timer_on;
    logic [TMR_W-1:0] r_timer_left;
    logic [NOW_W-1:0] r_now;
    logic signed [POS_W-1:0] r_press_x, r_press_y, r_last_x, r_last_y;

    // track
    logic signed [POS_W-1:0] r_tx [TRACK_DEPTH];
    logic signed [POS_W-1:0] r_ty [TRACK_DEPTH];
    logic [NOW_W-1:0]        r_tt [TRACK_DEPTH];
    logic [LW-1:0] r_len, r_rd, r_wr;
    logic r_walk, r_pause_go;

    // distance unit
    logic signed [POS_W-1:0] r_ref_x, r_ref_y;
    logic [2*POS_W-1:0] r_sq_x, r_sq_y;
    logic r_age_bad;

    // result
    logic [GES_W-1:0]        r_res_g, r_out_g;
    logic signed [POS_W-1:0] r_res_x, r_res_y, r_out_x, r_out_y;

    logic [IW-1:0] rd_idx, wr_idx;
    logic signed [POS_W-1:0] e_x, e_y;
    logic [NOW_W-1:0] e_t, age;
    logic signed [POS_W:0] dx, dy;
    logic [POS_W-1:0] adx, ady;
    logic [2*POS_W:0] dsum;
    logic [2*LIM_W-1:0] lim;
    logic far;
    logic [CNT_W-1:0] cc_inc;
    logic fresh;

    assign rd_idx = r_rd[IW-1:0];
    assign wr_idx = r_wr[IW-1:0];
    assign e_x = r_tx[rd_idx];
    assign e_y = r_ty[rd_idx];
    assign e_t = r_tt[rd_idx];
    assign age = r_now - e_t;
    assign dx  = {r_ref_x[POS_W-1], r_ref_x} - {e_x[POS_W-1], e_x};
    assign dy  = {r_ref_y[POS_W-1], r_ref_y} - {e_y[POS_W-1], e_y};
    assign adx = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    assign ady = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    assign lim  = r_dev_lim * r_dev_lim;
    assign dsum = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign far  = dsum > {{(2*POS_W+1-2*LIM_W){1'b0}}, lim};
    assign cc_inc = (r_cc < CNT_MAX) ? r_cc + 3'd1 : r_cc;
    assign fresh = (r_cc == '0) && !r_await_end && !r_await_rel;

    assign o_status.walk  = r_walk;
    assign o_status.pause = r_pause_go;
    assign o_status.more  = r_rd < r_len;
    assign o_out_data = {4'b0, r_out_y, r_out_x, r_out_g};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_to <= 12'd1400;
            r_ges_to <= 12'd400;
            r_pause_ivl <= 12'd1500;
            r_dev_lim <= 8'd10;
            r_drag_thr <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RELEASE_TO: r_rel_to    <= i_cfg_data;
                REG_GESTURE_TO: r_ges_to    <= i_cfg_data;
                REG_PAUSE_IVL:  r_pause_ivl <= i_cfg_data;
                REG_DEV_LIMIT:  r_dev_lim   <= i_cfg_data[LIM_W-1:0];
                REG_DRAG_THR:   r_drag_thr  <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_mode <= i_in_data[2:0];
                r_px   <= i_in_data[18:3];
                r_py   <= i_in_data[34:19];
                r_dd   <= i_in_data[50:35];
            end
            OP_RD: begin
                r_sq_x <= adx * adx;
                r_sq_y <= ady * ady;
                r_age_bad <= age > {4'b0, r_pause_ivl};
            end
            OP_P0: begin
                r_ref_x <= e_x;
                r_ref_y <= e_y;
            end
            OP_EXEC: begin
                r_ref_x <= r_px;
                r_ref_y <= r_py;
            end
            OP_CHK: begin
                if (!r_age_bad && !far) begin
                    r_tx[wr_idx] <= e_x;
                    r_ty[wr_idx] <= e_y;
                    r_tt[wr_idx] <= e_t;
                end
            end
            OP_PLACE: begin
                r_tx[wr_idx] <= r_ref_x;
                r_ty[wr_idx] <= r_ref_y;
                r_tt[wr_idx] <= r_now;
            end
            OP_OUT: begin
                r_out_g <= r_res_g;
                r_out_x <= r_res_x;
                r_out_y <= r_res_y;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= '0;
            r_await_rel <= 1'b0;
            r_await_end <= 1'b0;
            r_await_pause <= 1'b0;
            r_hold <= 1'b0;
            r_drag <= 1'b0;
            r_timer_on <= 1'b0;
            r_timer_left <= '0;
            r_now <= '0;
            r_press_x <= '0;
            r_press_y <= '0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_len <= '0;
            r_rd <= '0;
            r_wr <= '0;
            r_walk <= 1'b0;
            r_pause_go <= 1'b0;
            r_res_g <= GES_NONE;
            r_res_x <= '0;
            r_res_y <= '0;
        end else begin
            unique case (i_op)
                OP_EXEC: begin
                    r_res_g <= GES_NONE;
                    r_res_x <= '0;
                    r_res_y <= '0;
                    r_walk <= 1'b0;
                    r_pause_go <= 1'b0;
                    unique case (r_mode)
                        MODE_PRESS: begin
                            r_len <= '0;
                            r_await_pause <= 1'b0;
                            r_cc <= cc_inc;
                            if (cc_inc == 3'd1) begin
                                r_press_x <= r_px;
                                r_press_y <= r_py;
                                r_res_g <= GES_CLICK1;
                                r_res_x <= r_px;
                                r_res_y <= r_py;
                            end else if (cc_inc == 3'd2 || cc_inc == 3'd3) begin
                                r_res_g <= {1'b0, cc_inc};
                                r_res_x <= r_press_x;
                                r_res_y <= r_press_y;
                            end
                            r_await_end <= 1'b0;
                            r_timer_on <= 1'b1;
                            r_timer_left <= r_rel_to;
                            r_await_rel <= 1'b1;
                        end
                        MODE_RELEASE: begin
                            if (r_await_rel) begin
                                r_await_rel <= 1'b0;
                                r_timer_on <= 1'b1;
                                r_timer_left <= r_ges_to;
                                r_await_end <= 1'b1;
                            end
                            if (r_hold) begin
                                r_hold <= 1'b0;
                                r_cc <= '0;
                            end
                            r_drag <= 1'b0;
                        end
                        MODE_EXIT: begin
                            if (r_cc == '0) begin
                                r_timer_on <= 1'b0;
                                r_len <= '0;
                                r_await_pause <= 1'b0;
                            end
                        end
                        MODE_MOVE: begin
                            r_last_x <= r_px;
                            r_last_y <= r_py;
                            if (fresh) begin
                                r_await_pause <= 1'b1;
                                if (!r_timer_on) begin
                                    r_timer_on <= 1'b1;
                                    r_timer_left <= r_pause_ivl;
                                end
                                r_walk <= 1'b1;
                                // full track: oldest point is skipped
                                r_rd <= (r_len >= DEPTH_L) ? LW'(1) : '0;
                                r_wr <= '0;
                            end
                        end
                        MODE_DRAG: begin
                            if (r_drag || r_dd > {8'b0, r_drag_thr}) begin
                                r_drag <= 1'b1;
                                if (r_await_rel) begin
                                    r_await_rel <= 1'b0;
                                    r_hold <= 1'b1;
                                    r_res_g <= count_code(GES_DRAG1, r_cc);
                                    r_res_x <= r_press_x;
                                    r_res_y <= r_press_y;
                                end
                            end
                        end
                        MODE_TICK: begin
                            r_now <= r_now + 16'd1;
                            if (r_timer_on) begin
                                if (r_timer_left <= 12'd1) begin
                                    r_timer_on <= 1'b0;
                                    if (r_await_rel) begin
                                        r_await_rel <= 1'b0;
                                        r_hold <= 1'b1;
                                        r_res_g <= count_code(GES_HOLD1, r_cc);
                                        r_res_x <= r_last_x;
                                        r_res_y <= r_last_y;
                                    end else if (r_await_end) begin
                                        r_await_end <= 1'b0;
                                        r_cc <= '0;
                                    end else if (r_await_pause && r_len != '0) begin
                                        r_pause_go <= 1'b1;
                                        r_rd <= '0;
                                    end
                                end else begin
                                    r_timer_left <= r_timer_left - 12'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                OP_CHK: begin
                    r_rd <= r_rd + LW'(1);
                    if (r_age_bad) begin
                        // aged out: dropped
                    end else if (far) begin
                        r_timer_on <= 1'b1;
                        r_timer_left <= r_pause_ivl;
                    end else begin
                        r_wr <= r_wr + LW'(1);
                    end
                end
                OP_PLACE: begin
                    r_len <= r_wr + LW'(1);
                    r_walk <= 1'b0;
                end
                OP_P0: r_rd <= r_len - LW'(1);
                OP_PCHK: begin
                    r_pause_go <= 1'b0;
                    if (!far) begin
                        r_await_pause <= 1'b0;
                        r_res_g <= GES_PAUSE;
                        r_res_x <= e_x;
                        r_res_y <= e_y;
                    end else begin
                        r_timer_on <= 1'b1;
                        r_timer_left <= r_pause_ivl;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/pgc_ctrl.sv */
// Controller: sequences item execution, track walk, pause check and result hand-off.
module pgc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pgc_pkg::t_status i_status,
    output pgc_pkg::t_op     o_op
);
    import pgc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_BR, S_RD, S_CHK, S_PLACE, S_P0, S_P1, S_P2, S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (r_state)
            S_IDLE:  o_op = i_in_valid ? OP_LOAD : OP_IDLE;
            S_EXEC:  o_op = OP_EXEC;
            S_RD:    o_op = OP_RD;
            S_P1:    o_op = OP_RD;
            S_CHK:   o_op = OP_CHK;
            S_PLACE: o_op = OP_PLACE;
            S_P0:    o_op = OP_P0;
            S_P2:    o_op = OP_PCHK;
            S_DONE:  o_op = out_free ? OP_OUT : OP_IDLE;
            default: o_op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_EXEC;
                S_EXEC:  r_state <= S_BR;
                S_BR: begin
                    priority if (i_status.walk) r_state <= i_status.more ? S_RD : S_PLACE;
                    else if (i_status.pause) r_state <= S_P0;
                    else r_state <= S_DONE;
                end
                S_RD:    r_state <= S_CHK;
                S_CHK:   r_state <= S_BR;
                S_PLACE: r_state <= S_DONE;
                S_P0:    r_state <= S_P1;
                S_P1:    r_state <= S_P2;
                S_P2:    r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/pointer_gesture_classifier_core.sv */
// Top level of the pointer gesture classifier.
// Each accepted item passes through the execute, branch and done states before its result
// is registered; a move walks the track with a read and a check state per older stored point,
// and a pause check adds the P0, P1 and P2 states. One item at a time; a track walk or a
// result waiting in the output register holds off the next item.
// Reset: synchronous active-low; clears gesture state, timer and track length and
// restores the register defaults. Track entries are not cleared.
module pointer_gesture_classifier_core #(
    parameter int unsigned TRACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [pgc_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // mode, pos_x, pos_y, drag_distance
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [pgc_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // gesture, at_x, at_y
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pgc_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [pgc_pkg::CDAT_W-1:0] i_cfg_data
);
    import pgc_pkg::*;

    t_op     op;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pgc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_op        (op)
    );

    pgc_datapath #(.TRACK_DEPTH(TRACK_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata)
    );

endmodule

/* rtl/pgc_checker.sv */
// Port-level checker for the pointer gesture classifier, bound to the top level.
module pgc_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        o_cfg_ready
);
    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no gesture carries no position
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] == 4'd0 |-> m_axis_tdata[35:4] == 32'd0)
        else $error("none result with nonzero position");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd10)
        else $error("gesture code out of range");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");
endmodule

bind pointer_gesture_classifier_core pgc_assertions u_pgc_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .o_cfg_ready   (o_cfg_ready)
);
